// File: rtl/ah256_pkg.sv
`default_nettype none

package ah256_pkg;

    // Sponge geometry
    localparam int LANE_W     = 64;
    localparam int NUM_LANES  = 5;
    localparam int ROUNDS     = 12;
    localparam int ROUND_W    = 4;
    localparam int BYTES      = 8;
    localparam int COUNT_W    = 4;
    localparam int WORD_IDX_W = 2;

    // Input beat: message_block, valid_bytes, zero fill to 72 bits
    localparam int S_TDATA_W  = 72;
    // Output beat: digest_word, word_index, zero fill to 72 bits
    localparam int M_TDATA_W  = 72;

    localparam logic [ROUND_W-1:0]    LAST_ROUND = ROUND_W'(ROUNDS - 1);
    localparam logic [WORD_IDX_W-1:0] LAST_WORD  = 2'd3;

    localparam logic [LANE_W-1:0] HASH_IV   = 64'h0000_0801_00cc_0002;
    localparam logic [7:0]        PAD_BYTE  = 8'h01;
    localparam logic [LANE_W-1:0] PAD_BLOCK = {56'd0, PAD_BYTE};

    typedef logic [NUM_LANES-1:0][LANE_W-1:0] lanes_t;

    // What the back end does with one queued block
    typedef enum logic [1:0] {
        OP_ABSORB,       // absorb, no digest
        OP_FINAL,        // absorb padded block, then squeeze
        OP_PAD_FINAL     // absorb full block, absorb pad-only block, squeeze
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [LANE_W-1:0] data;
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } back_state_t;

    localparam lanes_t INIT_LOAD = {64'd0, 64'd0, 64'd0, 64'd0, HASH_IV};

    function automatic logic [7:0] ah_rc(logic [ROUND_W-1:0] r);
        logic [7:0] c;
        case (r)
            4'd0:    c = 8'hf0;
            4'd1:    c = 8'he1;
            4'd2:    c = 8'hd2;
            4'd3:    c = 8'hc3;
            4'd4:    c = 8'hb4;
            4'd5:    c = 8'ha5;
            4'd6:    c = 8'h96;
            4'd7:    c = 8'h87;
            4'd8:    c = 8'h78;
            4'd9:    c = 8'h69;
            4'd10:   c = 8'h5a;
            4'd11:   c = 8'h4b;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [LANE_W-1:0] rotr(logic [LANE_W-1:0] v, int n);
        return (v >> n) | (v << (LANE_W - n));
    endfunction

    // One Ascon round: constant addition, S-box layer, linear layer
    function automatic lanes_t ah_round(lanes_t s, logic [7:0] rc);
        logic [LANE_W-1:0] x0, x1, x2, x3, x4;
        logic [LANE_W-1:0] t0, t1, t2, t3, t4;
        lanes_t r;
        x0 = s[0];
        x1 = s[1];
        x2 = s[2] ^ {56'd0, rc};
        x3 = s[3];
        x4 = s[4];
        x0 = x0 ^ x4;
        x4 = x4 ^ x3;
        x2 = x2 ^ x1;
        t0 = ~x0 & x1;
        t1 = ~x1 & x2;
        t2 = ~x2 & x3;
        t3 = ~x3 & x4;
        t4 = ~x4 & x0;
        x0 = x0 ^ t1;
        x1 = x1 ^ t2;
        x2 = x2 ^ t3;
        x3 = x3 ^ t4;
        x4 = x4 ^ t0;
        x1 = x1 ^ x0;
        x0 = x0 ^ x4;
        x3 = x3 ^ x2;
        x2 = ~x2;
        r[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
        r[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
        r[2] = x2 ^ rotr(x2, 1)  ^ rotr(x2, 6);
        r[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
        r[4] = x4 ^ rotr(x4, 7)  ^ rotr(x4, 41);
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ah256_front.sv
`default_nettype none

module ah256_front (
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [ah256_pkg::S_TDATA_W-1:0]  s_tdata,   // [63:0] message_block, [67:64] valid_bytes
    input  wire logic                             s_tlast,   // is_final
    output logic                                  push,
    output ah256_pkg::op_t                        push_op,
    input  wire logic                             q_full
);

    logic [ah256_pkg::LANE_W-1:0]  block;
    logic [ah256_pkg::COUNT_W-1:0] count;
    logic [ah256_pkg::LANE_W-1:0]  short_block;

    assign block    = s_tdata[ah256_pkg::LANE_W-1:0];
    assign count    = s_tdata[ah256_pkg::LANE_W +: ah256_pkg::COUNT_W];
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // Short final block: keep bytes below count, pad byte at count, zero above
    always_comb begin
        for (int i = 0; i < ah256_pkg::BYTES; i++) begin
            if (ah256_pkg::COUNT_W'(i) < count) begin
                short_block[8*i +: 8] = block[8*i +: 8];
            end else if (ah256_pkg::COUNT_W'(i) == count) begin
                short_block[8*i +: 8] = ah256_pkg::PAD_BYTE;
            end else begin
                short_block[8*i +: 8] = 8'h00;
            end
        end
    end

    // Classify the beat
    always_comb begin
        if (!s_tlast) begin
            push_op.kind = ah256_pkg::OP_ABSORB;
            push_op.data = block;
        end else if (count[ah256_pkg::COUNT_W-1]) begin
            push_op.kind = ah256_pkg::OP_PAD_FINAL;
            push_op.data = block;
        end else begin
            push_op.kind = ah256_pkg::OP_FINAL;
            push_op.data = short_block;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ah256_queue.sv
`default_nettype none

module ah256_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire ah256_pkg::op_t  push_op,
    output logic                 full,
    output logic                 pop_valid,
    output ah256_pkg::op_t       pop_op,
    input  wire logic            pop
);

    // Two-entry queue of classified blocks
    ah256_pkg::op_t mem_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg,  count_next;
    logic           do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_op    = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

// File: rtl/ah256_back.sv
`default_nettype none

module ah256_back (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             q_valid,
    input  wire ah256_pkg::op_t                   q_op,
    output logic                                  q_pop,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [ah256_pkg::M_TDATA_W-1:0]       m_tdata,   // [63:0] digest_word, [65:64] word_index
    output logic                                  m_tlast    // last_word
);

    ah256_pkg::back_state_t             state_reg,  state_next;
    ah256_pkg::lanes_t                  lanes_reg,  lanes_next;
    ah256_pkg::lanes_t                  init_lanes_reg, init_lanes_next;
    logic [ah256_pkg::LANE_W-1:0]       op_data_reg, op_data_next;
    logic [ah256_pkg::ROUND_W-1:0]      round_reg,  round_next;
    logic                               init_reg,   init_next;
    logic                               pad_reg,    pad_next;
    logic                               final_reg,  final_next;
    logic [ah256_pkg::WORD_IDX_W-1:0]   word_reg,   word_next;

    logic                               out_valid_reg, out_valid_next;
    logic [ah256_pkg::LANE_W-1:0]       out_data_reg,  out_data_next;
    logic [ah256_pkg::WORD_IDX_W-1:0]   out_idx_reg,   out_idx_next;
    logic                               out_last_reg,  out_last_next;

    ah256_pkg::lanes_t                  rnd_in, rnd_out;
    logic                               last_rnd, out_free, take;

    // Round unit: block XOR folds into the first round's input
    always_comb begin
        rnd_in    = lanes_reg;
        rnd_in[0] = lanes_reg[0] ^ op_data_reg;
        rnd_out   = ah256_pkg::ah_round(rnd_in, ah256_pkg::ah_rc(round_reg));
    end

    assign last_rnd = (round_reg == ah256_pkg::LAST_ROUND);
    assign out_free = !out_valid_reg || m_tready;

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        lanes_next      = lanes_reg;
        init_lanes_next = init_lanes_reg;
        op_data_next    = op_data_reg;
        round_next      = round_reg;
        init_next       = init_reg;
        pad_next        = pad_reg;
        final_next      = final_reg;
        word_next       = word_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_idx_next    = out_idx_reg;
        out_last_next   = out_last_reg;
        take            = 1'b0;

        case (state_reg)
            ah256_pkg::ST_IDLE: begin
                take = q_valid;
            end
            ah256_pkg::ST_RUN: begin
                lanes_next   = rnd_out;
                op_data_next = '0;
                round_next   = round_reg + 4'd1;
                if (last_rnd) begin
                    round_next = '0;
                    if (init_reg) begin
                        init_lanes_next = rnd_out;
                        init_next       = 1'b0;
                        state_next      = ah256_pkg::ST_IDLE;
                    end else if (pad_reg) begin
                        op_data_next = ah256_pkg::PAD_BLOCK;
                        pad_next     = 1'b0;
                    end else if (final_reg) begin
                        state_next = ah256_pkg::ST_EMIT;
                    end else begin
                        state_next = ah256_pkg::ST_IDLE;
                        take       = q_valid;
                    end
                end
            end
            ah256_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = lanes_reg[0];
                    out_idx_next   = word_reg;
                    out_last_next  = (word_reg == ah256_pkg::LAST_WORD);
                    if (word_reg == ah256_pkg::LAST_WORD) begin
                        lanes_next = init_lanes_reg;
                        final_next = 1'b0;
                        word_next  = '0;
                        state_next = ah256_pkg::ST_IDLE;
                    end else begin
                        word_next    = word_reg + 2'd1;
                        op_data_next = '0;
                        round_next   = '0;
                        state_next   = ah256_pkg::ST_RUN;
                    end
                end
            end
            default: begin
                state_next = ah256_pkg::ST_IDLE;
            end
        endcase

        // Start the next queued block
        if (take) begin
            op_data_next = q_op.data;
            pad_next     = (q_op.kind == ah256_pkg::OP_PAD_FINAL);
            final_next   = (q_op.kind != ah256_pkg::OP_ABSORB);
            round_next   = '0;
            state_next   = ah256_pkg::ST_RUN;
        end
    end

    assign q_pop    = take;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ah256_pkg::M_TDATA_W - ah256_pkg::LANE_W - ah256_pkg::WORD_IDX_W){1'b0}},
                       out_idx_reg, out_data_reg};
    assign m_tlast  = out_last_reg;

    // Control and sponge state; reset starts the initial permutation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ah256_pkg::ST_RUN;
            lanes_reg     <= ah256_pkg::INIT_LOAD;
            op_data_reg   <= '0;
            round_reg     <= '0;
            init_reg      <= 1'b1;
            pad_reg       <= 1'b0;
            final_reg     <= 1'b0;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            lanes_reg     <= lanes_next;
            op_data_reg   <= op_data_next;
            round_reg     <= round_next;
            init_reg      <= init_next;
            pad_reg       <= pad_next;
            final_reg     <= final_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        init_lanes_reg <= init_lanes_next;
        out_data_reg   <= out_data_next;
        out_idx_reg    <= out_idx_next;
        out_last_reg   <= out_last_next;
    end

    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_last_reg |-> out_idx_reg == ah256_pkg::LAST_WORD)
        else $error("last beat without final word index");

    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ah256_pkg::ST_RUN |-> round_reg <= ah256_pkg::LAST_ROUND)
        else $error("round counter out of range");

    a_pad_final: assert property (@(posedge aclk) disable iff (!aresetn)
        pad_reg |-> final_reg)
        else $error("pad block pending outside a final message");

    a_no_take_init: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> !init_reg)
        else $error("block taken before initial state ready");

    a_emit_final: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ah256_pkg::ST_EMIT |-> final_reg && !pad_reg)
        else $error("digest output outside a final message");

endmodule

`default_nettype wire

// File: rtl/ascon_hash256_engine.sv
`default_nettype none

// Channel  Ports                   tdata (low bit up)                    tlast
// input    s_tvalid/s_tready       message_block[63:0], valid_bytes[67:64] is_final
// output   m_tvalid/m_tready       digest_word[63:0], word_index[65:64]   last_word
//
// Each 64-bit block runs through the one-round-per-cycle unit, back to back.
// A final beat adds a permutation for each of the three later digest words, an ST_EMIT
// step per word, a return to ST_IDLE after the last word, and one more if it has 8 bytes.
// After reset the back end permutes the initial state; the queue fills meanwhile.
// Output stalls hold the back end only while a digest word waits; the queue keeps
// taking beats until full.

module ascon_hash256_engine (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [ah256_pkg::S_TDATA_W-1:0]  s_tdata,   // [63:0] message_block, [67:64] valid_bytes
    input  wire logic                             s_tlast,   // is_final
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [ah256_pkg::M_TDATA_W-1:0]       m_tdata,   // [63:0] digest_word, [65:64] word_index
    output logic                                  m_tlast    // last_word
);

    logic           push, q_full, q_valid, q_pop;
    ah256_pkg::op_t push_op, q_op;

    ah256_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .push     (push),
        .push_op  (push_op),
        .q_full   (q_full)
    );

    ah256_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_op   (push_op),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_op    (q_op),
        .pop       (q_pop)
    );

    ah256_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_op     (q_op),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
